// File: src/bdq_pkg.sv
// shared types, constants and helpers for the bounded deque core
package bdq_pkg;

    // queue geometry
    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    // request kinds carried on s_tuser
    typedef enum logic [2:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_READ       = 3'd4,
        KIND_DELETE     = 3'd5,
        KIND_FOLD       = 3'd6,
        KIND_NONE       = 3'd7
    } kind_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_RANGE    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    // ring slot of base plus offset, both below DEPTH
    function automatic logic [IDX_W-1:0] slot_add(
        input logic [IDX_W-1:0] base,
        input logic [IDX_W-1:0] off
    );
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (IDX_W + 1)'(DEPTH))
        begin
            sum = sum - (IDX_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    // ring slot one before base
    function automatic logic [IDX_W-1:0] slot_dec(input logic [IDX_W-1:0] base);
        logic [IDX_W-1:0] res;
        if (base == '0)
        begin
            res = IDX_W'(DEPTH - 1);
        end
        else
        begin
            res = base - 1'b1;
        end
        return res;
    endfunction

endpackage

// File: src/bounded_deque_with_value_delete_core.sv
// bounded double-ended queue of signed 32-bit values with value delete and fold
//
// One request at a time: s_tready is high only while the core is idle, and
// each request gives exactly one result on the m_ side. Push requests, the
// unused kind and rejected requests go from S_EXEC straight to S_RESP; pops
// and indexed reads that find an entry pass through S_FETCH, bound by the
// registered read of the entry ram. Delete-value and fold walk the held
// entries through the single ram read port, one entry per cycle. The fold is
// Horner's rule from the front (acc * 10 + entry, wrapping at 32 bits) on one
// shared shift-and-add unit. Delete compacts the survivors in place during the
// same walk. Entries are not cleared on reset; only data read from slots that
// hold entries is ever used.
module bounded_deque_with_value_delete_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value[31:0], position[39:32]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // data[31:0], status[34:32], occupancy[39:35]
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_FETCH = 5'b00100,
        S_WALK  = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    bdq_pkg::kind_t                   kind_reg, kind_next;
    logic signed [bdq_pkg::DATA_W-1:0] value_reg, value_next;
    logic [7:0]                       position_reg, position_next;
    logic [bdq_pkg::IDX_W-1:0]        front_reg, front_next;
    logic [bdq_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [bdq_pkg::CNT_W-1:0]        rd_cnt_reg, rd_cnt_next;
    logic [bdq_pkg::CNT_W-1:0]        wr_cnt_reg, wr_cnt_next;
    logic                             pend_reg, pend_next;
    logic [bdq_pkg::DATA_W-1:0]       data_reg, data_next;
    bdq_pkg::status_t                 status_reg, status_next;

    // ram ports
    logic                       ram_we;
    logic [bdq_pkg::IDX_W-1:0]  ram_waddr;
    logic [bdq_pkg::DATA_W-1:0] ram_wdata;
    logic [bdq_pkg::IDX_W-1:0]  ram_raddr;
    logic [bdq_pkg::DATA_W-1:0] ram_rdata;

    logic [bdq_pkg::DATA_W-1:0] fold_sum;
    logic                       full;
    logic                       empty;

    bdq_ram #(
        .WIDTH(bdq_pkg::DATA_W),
        .DEPTH(bdq_pkg::DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign full  = (count_reg == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
    assign empty = (count_reg == '0);

    // shared shift-and-add unit: acc * 10 + entry
    assign fold_sum = (data_reg << 3) + (data_reg << 1) + ram_rdata;

    // handshake and result
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_RESP);
    assign m_tdata  = {5'(count_reg), status_reg, data_reg};

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        value_next    = value_reg;
        position_next = position_reg;
        front_next    = front_reg;
        count_next    = count_reg;
        rd_cnt_next   = rd_cnt_reg;
        wr_cnt_next   = wr_cnt_reg;
        pend_next     = 1'b0;
        data_next     = data_reg;
        status_next   = status_reg;
        ram_we        = 1'b0;
        ram_waddr     = front_reg;
        ram_wdata     = value_reg;
        ram_raddr     = front_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next     = bdq_pkg::kind_t'(s_tuser);
                    value_next    = s_tdata[31:0];
                    position_next = s_tdata[39:32];
                    data_next     = '0;
                    status_next   = bdq_pkg::ST_OK;
                    rd_cnt_next   = '0;
                    wr_cnt_next   = '0;
                    state_next    = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_RESP;
                case (kind_reg) inside
                    bdq_pkg::KIND_PUSH_FRONT:
                    begin
                        if (full)
                        begin
                            status_next = bdq_pkg::ST_FULL;
                        end
                        else
                        begin
                            front_next = bdq_pkg::slot_dec(front_reg);
                            ram_we     = 1'b1;
                            ram_waddr  = bdq_pkg::slot_dec(front_reg);
                            count_next = count_reg + 1'b1;
                        end
                    end
                    bdq_pkg::KIND_PUSH_BACK:
                    begin
                        if (full)
                        begin
                            status_next = bdq_pkg::ST_FULL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = bdq_pkg::slot_add(front_reg,
                                                           count_reg[bdq_pkg::IDX_W-1:0]);
                            count_next = count_reg + 1'b1;
                        end
                    end
                    bdq_pkg::KIND_POP_FRONT:
                    begin
                        if (empty)
                        begin
                            status_next = bdq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            ram_raddr  = front_reg;
                            front_next = bdq_pkg::slot_add(front_reg, bdq_pkg::IDX_W'(1));
                            count_next = count_reg - 1'b1;
                            state_next = S_FETCH;
                        end
                    end
                    bdq_pkg::KIND_POP_BACK:
                    begin
                        if (empty)
                        begin
                            status_next = bdq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            ram_raddr  = bdq_pkg::slot_add(front_reg,
                                             bdq_pkg::IDX_W'(count_reg - 1'b1));
                            count_next = count_reg - 1'b1;
                            state_next = S_FETCH;
                        end
                    end
                    bdq_pkg::KIND_READ:
                    begin
                        if (32'(position_reg) >= 32'(count_reg))
                        begin
                            status_next = bdq_pkg::ST_RANGE;
                        end
                        else
                        begin
                            ram_raddr  = bdq_pkg::slot_add(front_reg,
                                                           bdq_pkg::IDX_W'(position_reg));
                            state_next = S_FETCH;
                        end
                    end
                    bdq_pkg::KIND_DELETE, bdq_pkg::KIND_FOLD:
                    begin
                        state_next = S_WALK;
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end

            S_FETCH:
            begin
                data_next  = ram_rdata;
                state_next = S_RESP;
            end

            S_WALK:
            begin
                // issue the next entry read
                if (rd_cnt_reg < count_reg)
                begin
                    ram_raddr   = bdq_pkg::slot_add(front_reg,
                                                    rd_cnt_reg[bdq_pkg::IDX_W-1:0]);
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                    pend_next   = 1'b1;
                end

                // consume the entry read last cycle
                if (pend_reg)
                begin
                    if (kind_reg == bdq_pkg::KIND_FOLD)
                    begin
                        data_next = fold_sum;
                    end
                    else if (ram_rdata != value_reg)
                    begin
                        ram_we      = 1'b1;
                        ram_waddr   = bdq_pkg::slot_add(front_reg,
                                                        wr_cnt_reg[bdq_pkg::IDX_W-1:0]);
                        ram_wdata   = ram_rdata;
                        wr_cnt_next = wr_cnt_reg + 1'b1;
                    end
                end

                // walk finished
                if ((rd_cnt_reg == count_reg) && !pend_reg)
                begin
                    state_next = S_RESP;
                    if (kind_reg == bdq_pkg::KIND_DELETE)
                    begin
                        if (wr_cnt_reg == count_reg)
                        begin
                            status_next = bdq_pkg::ST_NOTFOUND;
                        end
                        else
                        begin
                            count_next = wr_cnt_reg;
                        end
                    end
                end
            end

            S_RESP:
            begin
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            kind_reg   <= bdq_pkg::KIND_NONE;
            front_reg  <= '0;
            count_reg  <= '0;
            rd_cnt_reg <= '0;
            wr_cnt_reg <= '0;
            pend_reg   <= 1'b0;
            status_reg <= bdq_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            kind_reg   <= kind_next;
            front_reg  <= front_next;
            count_reg  <= count_next;
            rd_cnt_reg <= rd_cnt_next;
            wr_cnt_reg <= wr_cnt_next;
            pend_reg   <= pend_next;
            status_reg <= status_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        position_reg <= position_next;
        data_reg     <= data_next;
    end

endmodule

// File: src/bdq_ram.sv
// generic single-write, single-read ram with registered read data
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: dv/bounded_deque_with_value_delete_core_test.sv
// stream-level testbench for the bounded deque core with a predicting scoreboard
`timescale 1ns / 100ps

module bounded_deque_with_value_delete_core_test;
    import bdq_pkg::*;

    localparam int REPORT_LIMIT    = 10;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int HOLD_OFF_AFTER  = 400;
    localparam int QUIET_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int BLOCKS          = 35;
    localparam int BLOCK_ITEMS     = 50;

    localparam logic [31:0] VAL_MAX_POS  = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_MIN_NEG  = 32'h8000_0000;
    localparam logic [31:0] VAL_ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [31:0] VAL_ZERO     = 32'h0000_0000;
    localparam logic [7:0]  POS_MAX      = 8'hFF;

    // traffic shapes for the random part
    typedef enum logic [1:0] {
        MIX_GROW,
        MIX_EVEN,
        MIX_SHRINK
    } traffic_mix_t;

    // one result as the core reports it
    typedef struct packed {
        logic [DATA_W-1:0] data;
        status_t           status;
        logic [CNT_W-1:0]  occupancy;
    } deque_result_t;

    // mirror of the deque contents plus the results still owed by the core
    class deque_scoreboard;
        logic [DATA_W-1:0] stored_values[$];
        deque_result_t     pending_results[$];
        int                failures;
        int                results_checked;
        int                requests_noted;
        int                peak_occupancy;
        int                kinds_seen[8];
        int                statuses_seen[8];

        // apply one accepted request to the mirror and queue its result
        function void note_request(kind_t kind, logic [DATA_W-1:0] value,
                                   logic [7:0] position);
            deque_result_t     res;
            logic [DATA_W-1:0] survivors[$];
            logic [DATA_W-1:0] acc;
            res.data   = '0;
            res.status = ST_OK;
            case (kind) inside
                KIND_PUSH_FRONT, KIND_PUSH_BACK:
                begin
                    if (stored_values.size() >= DEPTH)
                    begin
                        res.status = ST_FULL;
                    end
                    else if (kind == KIND_PUSH_FRONT)
                    begin
                        stored_values.insert(0, value);
                    end
                    else
                    begin
                        stored_values.insert(stored_values.size(), value);
                    end
                end
                KIND_POP_FRONT:
                begin
                    if (stored_values.size() == 0)
                    begin
                        res.status = ST_EMPTY;
                    end
                    else
                    begin
                        res.data = stored_values.pop_front();
                    end
                end
                KIND_POP_BACK:
                begin
                    if (stored_values.size() == 0)
                    begin
                        res.status = ST_EMPTY;
                    end
                    else
                    begin
                        res.data = stored_values.pop_back();
                    end
                end
                KIND_READ:
                begin
                    if (int'(position) >= stored_values.size())
                    begin
                        res.status = ST_RANGE;
                    end
                    else
                    begin
                        res.data = stored_values[position];
                    end
                end
                KIND_DELETE:
                begin
                    // survivors keep their order and close up from the front
                    foreach (stored_values[i])
                    begin
                        if (stored_values[i] != value)
                        begin
                            survivors.insert(survivors.size(), stored_values[i]);
                        end
                    end
                    if (survivors.size() == stored_values.size())
                    begin
                        res.status = ST_NOTFOUND;
                    end
                    else
                    begin
                        stored_values = survivors;
                    end
                end
                KIND_FOLD:
                begin
                    // front entry carries the highest power of ten, wrap at 32 bits
                    acc = '0;
                    foreach (stored_values[i])
                    begin
                        acc = acc * 32'd10 + stored_values[i];
                    end
                    res.data = acc;
                end
                default:
                begin
                end
            endcase
            res.occupancy = CNT_W'(stored_values.size());
            pending_results.insert(pending_results.size(), res);
            requests_noted++;
            kinds_seen[kind]++;
            statuses_seen[res.status]++;
            if (stored_values.size() > peak_occupancy)
            begin
                peak_occupancy = stored_values.size();
            end
        endfunction

        // compare one result transaction with the oldest expectation
        function void check_result(logic [39:0] word);
            deque_result_t     want;
            logic [DATA_W-1:0] got_data;
            logic [2:0]        got_status;
            logic [CNT_W-1:0]  got_occupancy;
            got_data      = word[31:0];
            got_status    = word[34:32];
            got_occupancy = word[39:35];
            results_checked++;
            if (pending_results.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                begin
                    $display("%0t: result %h arrived with no request outstanding",
                             $realtime, word);
                end
                return;
            end
            want = pending_results.pop_front();
            if (got_data !== want.data || got_status !== want.status ||
                got_occupancy !== want.occupancy)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                begin
                    $display("%0t: result %0d mismatch: data exp %h got %h, ",
                             $realtime, results_checked, want.data, got_data,
                             "status exp %0d got %0d, occupancy exp %0d got %0d",
                             want.status, got_status, want.occupancy, got_occupancy);
                end
            end
        endfunction

        // anything still owed at the end counts as a failure
        function void close_out();
            if (pending_results.size() != 0)
            begin
                failures += pending_results.size();
                $display("%0d expected results never arrived", pending_results.size());
            end
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // value[31:0], position[39:32]
    logic [2:0]  s_tuser  = '0;   // kind[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // data[31:0], status[34:32], occupancy[39:35]

    deque_scoreboard sb;
    logic            steady          = 1'b0;
    logic            backpressure_done = 1'b0;
    int              quiet_cycles    = 0;

    bounded_deque_with_value_delete_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 12 ns clock
    always #6 clk = ~clk;

    // offer one request, wait for the handshake, then record it
    task automatic issue_request(input kind_t kind, input logic [DATA_W-1:0] value,
                                 input logic [7:0] position);
        while (!steady && $urandom_range(99) < 34)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {position, value};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        sb.note_request(kind, value, position);
    endtask

    // small pool for repeats, corner values, otherwise full range
    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(9);
        if (r < 4)
        begin
            return DATA_W'($urandom_range(5));
        end
        if (r == 4)
        begin
            case ($urandom_range(3))
                0:       return VAL_MAX_POS;
                1:       return VAL_MIN_NEG;
                2:       return VAL_ALL_ONES;
                default: return VAL_ZERO;
            endcase
        end
        return $urandom();
    endfunction

    // choose the next request from the mix and the current contents
    task automatic pick_request(input traffic_mix_t mix, output kind_t kind,
                                output logic [DATA_W-1:0] value,
                                output logic [7:0] position);
        int r;
        int held;
        int push_cut;
        int pop_cut;
        int read_cut;
        int del_cut;
        int fold_cut;
        held = sb.stored_values.size();
        case (mix)
            MIX_GROW:
            begin
                push_cut = 55; pop_cut = 65; read_cut = 75; del_cut = 85; fold_cut = 95;
            end
            MIX_SHRINK:
            begin
                push_cut = 15; pop_cut = 60; read_cut = 72; del_cut = 85; fold_cut = 95;
            end
            default:
            begin
                push_cut = 35; pop_cut = 55; read_cut = 70; del_cut = 83; fold_cut = 96;
            end
        endcase
        r        = $urandom_range(99);
        value    = pick_value();
        position = 8'($urandom_range(255));
        if (r < push_cut)
        begin
            kind = $urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
        end
        else if (r < pop_cut)
        begin
            kind = $urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT;
        end
        else if (r < read_cut)
        begin
            kind = KIND_READ;
            r    = $urandom_range(9);
            if (held > 0 && r < 7)
            begin
                position = 8'($urandom_range(held - 1));
            end
            else if (r < 9)
            begin
                position = 8'(held + $urandom_range(2));
            end
        end
        else if (r < del_cut)
        begin
            // mostly delete something that is actually held
            kind = KIND_DELETE;
            if (held > 0 && $urandom_range(9) < 7)
            begin
                value = sb.stored_values[$urandom_range(held - 1)];
            end
        end
        else if (r < fold_cut)
        begin
            kind = KIND_FOLD;
        end
        else
        begin
            kind = KIND_NONE;
        end
    endtask

    // result side: random stalls, one long hold-off, a quiet stretch when steady
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!backpressure_done && sb.results_checked >= HOLD_OFF_AFTER)
            begin
                backpressure_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            m_tready <= steady || ($urandom_range(99) >= 34);
        end
    end

    // check every result transaction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_result(m_tdata);
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout after %0d cycles without a transaction", quiet_cycles);
                $display("bounded_deque_with_value_delete_core_test: done, errors");
                $finish;
            end
        end
    end

    // main sequence
    initial
    begin
        kind_t             kind;
        logic [DATA_W-1:0] value;
        logic [7:0]        position;
        traffic_mix_t      mix;

        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty-queue corners and the unused kind
        issue_request(KIND_POP_FRONT, VAL_ZERO, 8'd0);
        issue_request(KIND_POP_BACK, VAL_ZERO, 8'd0);
        issue_request(KIND_READ, VAL_ZERO, 8'd0);
        issue_request(KIND_DELETE, VAL_ZERO, 8'd0);
        issue_request(KIND_FOLD, VAL_ZERO, 8'd0);
        issue_request(KIND_NONE, VAL_ALL_ONES, POS_MAX);

        // extremes at both ends, reads in and out of range, fold with wrap
        issue_request(KIND_PUSH_BACK, VAL_MAX_POS, 8'd0);
        issue_request(KIND_PUSH_FRONT, VAL_MIN_NEG, 8'd0);
        issue_request(KIND_PUSH_BACK, VAL_ZERO, 8'd0);
        issue_request(KIND_PUSH_BACK, VAL_ALL_ONES, POS_MAX);
        issue_request(KIND_READ, VAL_ZERO, 8'd0);
        issue_request(KIND_READ, VAL_ZERO, 8'd3);
        issue_request(KIND_READ, VAL_ZERO, 8'd4);
        issue_request(KIND_READ, VAL_ZERO, POS_MAX);
        issue_request(KIND_FOLD, VAL_ZERO, 8'd0);

        // delete at the front, a miss, and a repeated value at the back
        issue_request(KIND_DELETE, VAL_MIN_NEG, 8'd0);
        issue_request(KIND_DELETE, 32'd5, 8'd0);
        issue_request(KIND_PUSH_BACK, VAL_ALL_ONES, 8'd0);
        issue_request(KIND_DELETE, VAL_ALL_ONES, 8'd0);

        // pops from the front down to empty, then a single entry popped from the back
        issue_request(KIND_POP_FRONT, VAL_ZERO, 8'd0);
        issue_request(KIND_POP_FRONT, VAL_ZERO, 8'd0);
        issue_request(KIND_PUSH_FRONT, 32'd123, 8'd0);
        issue_request(KIND_POP_BACK, VAL_ZERO, 8'd0);

        // random traffic in blocks that fill, churn and drain the queue
        for (int blk = 0; blk < BLOCKS; blk++)
        begin
            mix    = traffic_mix_t'(blk % 3);
            steady = (blk >= 18 && blk < 24);
            for (int n = 0; n < BLOCK_ITEMS; n++)
            begin
                pick_request(mix, kind, value, position);
                issue_request(kind, value, position);
            end
        end
        steady   = 1'b0;
        s_tvalid <= 1'b0;

        // drain, then give stray results time to show up
        while (sb.pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.close_out();

        $display("covered %0d requests: push %0d/%0d, pop %0d/%0d, ",
                 sb.requests_noted, sb.kinds_seen[KIND_PUSH_FRONT],
                 sb.kinds_seen[KIND_PUSH_BACK], sb.kinds_seen[KIND_POP_FRONT],
                 sb.kinds_seen[KIND_POP_BACK],
                 "read %0d, delete %0d, fold %0d, unused kind %0d",
                 sb.kinds_seen[KIND_READ], sb.kinds_seen[KIND_DELETE],
                 sb.kinds_seen[KIND_FOLD], sb.kinds_seen[KIND_NONE]);
        $display("outcomes ok %0d, empty %0d, full %0d, ",
                 sb.statuses_seen[ST_OK], sb.statuses_seen[ST_EMPTY],
                 sb.statuses_seen[ST_FULL],
                 "out of range %0d, not found %0d; peak fill %0d",
                 sb.statuses_seen[ST_RANGE], sb.statuses_seen[ST_NOTFOUND],
                 sb.peak_occupancy);
        if (sb.failures == 0)
        begin
            $display("bounded_deque_with_value_delete_core_test: done, clean");
        end
        else
        begin
            $display("%0d failures", sb.failures);
            $display("bounded_deque_with_value_delete_core_test: done, errors");
        end
        $finish;
    end

endmodule

// File: sim.f
src/bdq_pkg.sv
src/bdq_ram.sv
src/bounded_deque_with_value_delete_core.sv
dv/bounded_deque_with_value_delete_core_test.sv
